>>> sv/tlvd_pkg.sv
// Package for the TLV header deframer: item types, register map, status codes
// and size constants. No dependencies.
package tlvd_pkg;

  localparam longint unsigned DEF_MAX_BUFFER_BYTES = 64'd16777216;
  localparam longint unsigned MAX_COUNT            = 64'd65535;
  localparam logic [15:0]     CNT_SAT              = (MAX_COUNT < 64'd65535) ?
                                                     16'(MAX_COUNT) : 16'hffff;

  localparam int unsigned FIFO_DEPTH = 8;
  localparam int unsigned FIFO_AW    = $clog2(FIFO_DEPTH);

  localparam int unsigned PADDR_W = 5;

  localparam logic [15:0] RST_MAX_RECORDS  = 16'd0;
  localparam logic [7:0]  RST_WIDE_MASK    = 8'h80;
  localparam logic [7:0]  RST_NONCRIT_MASK = 8'h40;
  localparam logic [7:0]  RST_FWD_MASK     = 8'h20;
  localparam logic [7:0]  RST_TYPE_MASK    = 8'h1f;

  typedef enum logic [2:0] {
    REG_MAX_RECORDS  = 3'd0,
    REG_WIDE_MASK    = 3'd1,
    REG_NONCRIT_MASK = 3'd2,
    REG_FWD_MASK     = 3'd3,
    REG_TYPE_MASK    = 3'd4
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK               = 2'd0,
    ST_INVALID_ARGUMENT = 2'd1,
    ST_INVALID_FORMAT   = 2'd2
  } status_e;

  localparam logic KIND_RECORD  = 1'b0;
  localparam logic KIND_SUMMARY = 1'b1;

  typedef struct packed {
    logic [15:0] max_records;
    logic [7:0]  wide_header_mask;
    logic [7:0]  non_critical_mask;
    logic [7:0]  forward_mask;
    logic [7:0]  type_mask;
  } cfg_t;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic        record_kind;
    logic [15:0] tag;
    logic [2:0]  header_length;
    logic [15:0] data_length;
    logic [23:0] offset;
    logic        non_critical;
    logic        forward;
    logic [15:0] record_count;
    logic [1:0]  status;
    logic        last;
  } out_item_t;

  // up to two results per byte, in order: first then second
  typedef struct packed {
    logic [1:0] num;
    out_item_t  first;
    out_item_t  second;
  } push_t;

endpackage

>>> sv/tlvd_if.sv
// Valid/ready channel interfaces for the byte input and the result output.
// Depends on tlvd_pkg.
interface tlvd_in_if
  import tlvd_pkg::*;
();
  logic     valid;
  logic     ready;
  in_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

interface tlvd_out_if
  import tlvd_pkg::*;
();
  logic      valid;
  logic      ready;
  out_item_t item;

  modport source (output valid, output item, input ready);
  modport sink   (input valid, input item, output ready);
endinterface

>>> sv/tlv_header_deframer.sv
// Top level of the TLV header deframer: register file, parser, result queue.
// Depends on tlvd_pkg, tlvd_if, tlvd_cfg, tlvd_parser, tlvd_out_fifo.
//
//   channel   dir  handshake     payload
//   byte_i    in   valid/ready   byte_value, last_byte
//   result_o  out  valid/ready   record or end-of-buffer summary
//   apb       in   psel/penable  5 registers at 4*i, pready tied high
//
// One byte per cycle is accepted while ready is high.
// A final byte that also closes a TLV gives two results. The 8-entry result
// queue drains one a cycle while result_o is ready; ready drops while it
// holds more than four. Reset (rst_ni low, asynchronous) restores the
// register defaults and clears the parse state; no clearing pass.
module tlv_header_deframer
  import tlvd_pkg::*;
#(
  parameter longint unsigned MAX_BUFFER_BYTES = DEF_MAX_BUFFER_BYTES
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tlvd_in_if.sink            byte_i,
  tlvd_out_if.source         result_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  cfg_t  cfg;
  push_t push;
  logic  space;
  logic  accept;

  assign byte_i.ready = space;
  assign accept       = byte_i.valid & space;

  tlvd_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  tlvd_parser #(
    .MAX_BUFFER_BYTES (MAX_BUFFER_BYTES)
  ) u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .in_item_i  (byte_i.item),
    .cfg_i      (cfg),
    .push_o     (push)
  );

  tlvd_out_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .space_o (space),
    .valid_o (result_o.valid),
    .ready_i (result_o.ready),
    .item_o  (result_o.item)
  );

endmodule

>>> sv/tlvd_cfg.sv
// APB-style register file holding the record limit and header bit masks.
// Depends on tlvd_pkg.
module tlvd_cfg
  import tlvd_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  output cfg_t               cfg_o
);

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[PADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_records       <= RST_MAX_RECORDS;
      cfg_q.wide_header_mask  <= RST_WIDE_MASK;
      cfg_q.non_critical_mask <= RST_NONCRIT_MASK;
      cfg_q.forward_mask      <= RST_FWD_MASK;
      cfg_q.type_mask         <= RST_TYPE_MASK;
    end else if (wr_en) begin
      case (idx)
        REG_MAX_RECORDS:  cfg_q.max_records       <= pwdata[15:0];
        REG_WIDE_MASK:    cfg_q.wide_header_mask  <= pwdata[7:0];
        REG_NONCRIT_MASK: cfg_q.non_critical_mask <= pwdata[7:0];
        REG_FWD_MASK:     cfg_q.forward_mask      <= pwdata[7:0];
        REG_TYPE_MASK:    cfg_q.type_mask         <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_MAX_RECORDS:  prdata = {16'd0, cfg_q.max_records};
      REG_WIDE_MASK:    prdata = {24'd0, cfg_q.wide_header_mask};
      REG_NONCRIT_MASK: prdata = {24'd0, cfg_q.non_critical_mask};
      REG_FWD_MASK:     prdata = {24'd0, cfg_q.forward_mask};
      REG_TYPE_MASK:    prdata = {24'd0, cfg_q.type_mask};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

>>> sv/tlvd_parser.sv
// Input register and TLV parse state: one byte per cycle, up to two results.
// Depends on tlvd_pkg.
module tlvd_parser
  import tlvd_pkg::*;
#(
  parameter longint unsigned MAX_BUFFER_BYTES = DEF_MAX_BUFFER_BYTES
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  in_item_t in_item_i,
  input  cfg_t     cfg_i,
  output push_t    push_o
);

  localparam int unsigned POS_W   = $clog2(MAX_BUFFER_BYTES);
  localparam logic [POS_W:0] BUF_LIM = (POS_W + 1)'(MAX_BUFFER_BYTES);

  typedef enum logic [1:0] {
    PH_HEADER  = 2'd0,
    PH_VALUE   = 2'd1,
    PH_STOPPED = 2'd2
  } phase_e;

  logic             in_v_q;
  in_item_t         in_q;
  phase_e           phase_q, phase_d;
  logic [1:0]       hidx_q, hidx_d;
  logic [7:0]       first_q, first_d;
  logic [15:0]      tag_q, tag_d;
  logic [15:0]      vlen_q, vlen_d;
  logic [15:0]      left_q, left_d;
  logic [POS_W-1:0] start_q, start_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [15:0]      cnt_q, cnt_d;
  status_e          err_q, err_d;

  logic                 emit, finish;
  logic [15:0]          left_dec;
  logic [POS_W:0]       pos_inc;
  logic [POS_W+23:0]    start_ext;
  out_item_t            rec, summ;
  logic [7:0]           b;
  logic                 lastb;

  assign b         = in_q.byte_value;
  assign lastb     = in_q.last_byte;
  assign left_dec  = (left_q != 16'd0) ? left_q - 16'd1 : 16'd0;
  assign pos_inc   = {1'b0, pos_q} + (POS_W + 1)'(1);
  // a TLV never starts and ends on the same byte, so the held start is its offset
  assign start_ext = {24'd0, start_q};

  always_comb begin
    phase_d = phase_q;
    hidx_d  = hidx_q;
    first_d = first_q;
    tag_d   = tag_q;
    vlen_d  = vlen_q;
    left_d  = left_q;
    start_d = start_q;
    pos_d   = pos_q;
    cnt_d   = cnt_q;
    err_d   = err_q;
    emit    = 1'b0;
    finish  = 1'b0;
    rec     = '0;
    summ    = '0;
    push_o  = '0;

    if (in_v_q) begin
      case (phase_q)
        PH_VALUE: begin
          left_d = left_dec;
          if (left_dec == 16'd0) emit = 1'b1;
          else if (lastb) err_d = ST_INVALID_FORMAT;
        end
        PH_HEADER: begin
          case (hidx_q)
            2'd0: begin
              if (cfg_i.max_records != 16'd0 && cnt_q >= cfg_i.max_records) begin
                phase_d = PH_STOPPED;
              end else begin
                first_d = b;
                start_d = pos_q;
                if (lastb) err_d = ST_INVALID_ARGUMENT;
                else hidx_d = 2'd1;
              end
            end
            2'd1: begin
              if ((first_q & cfg_i.wide_header_mask) != 8'd0) begin
                tag_d = {first_q & cfg_i.type_mask, b};
                if (lastb) err_d = ST_INVALID_FORMAT;
                else hidx_d = 2'd2;
              end else begin
                tag_d  = {8'd0, first_q & cfg_i.type_mask};
                vlen_d = {8'd0, b};
                finish = 1'b1;
              end
            end
            2'd2: begin
              vlen_d = {b, 8'd0};
              if (lastb) err_d = ST_INVALID_FORMAT;
              else hidx_d = 2'd3;
            end
            default: begin
              vlen_d = {vlen_q[15:8], b};
              finish = 1'b1;
            end
          endcase
          if (finish) begin
            hidx_d = 2'd0;
            if (vlen_d == 16'd0) begin
              emit = 1'b1;
            end else begin
              left_d  = vlen_d;
              phase_d = PH_VALUE;
              if (lastb) err_d = ST_INVALID_FORMAT;
            end
          end
        end
        default: ;
      endcase

      if (emit) begin
        if (cnt_q < CNT_SAT) cnt_d = cnt_q + 16'd1;
        phase_d            = PH_HEADER;
        hidx_d             = 2'd0;
        rec.record_kind    = KIND_RECORD;
        rec.tag            = tag_d;
        rec.header_length  = ((first_d & cfg_i.wide_header_mask) != 8'd0) ? 3'd4 : 3'd2;
        rec.data_length    = vlen_d;
        rec.offset         = start_ext[23:0];
        rec.non_critical   = (first_d & cfg_i.non_critical_mask) != 8'd0;
        rec.forward        = (first_d & cfg_i.forward_mask) != 8'd0;
        rec.record_count   = cnt_d;
        rec.status         = ST_OK;
        rec.last           = 1'b0;
      end

      pos_d = (pos_inc >= BUF_LIM) ? '0 : pos_inc[POS_W-1:0];

      summ.record_kind  = KIND_SUMMARY;
      summ.record_count = cnt_d;
      summ.status       = err_d;
      summ.last         = 1'b1;

      if (emit && lastb) begin
        push_o.num    = 2'd2;
        push_o.first  = rec;
        push_o.second = summ;
      end else if (emit) begin
        push_o.num   = 2'd1;
        push_o.first = rec;
      end else if (lastb) begin
        push_o.num   = 2'd1;
        push_o.first = summ;
      end

      if (lastb) begin
        phase_d = PH_HEADER;
        hidx_d  = 2'd0;
        first_d = 8'd0;
        tag_d   = 16'd0;
        vlen_d  = 16'd0;
        left_d  = 16'd0;
        start_d = '0;
        pos_d   = '0;
        cnt_d   = 16'd0;
        err_d   = ST_OK;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q  <= 1'b0;
      phase_q <= PH_HEADER;
      hidx_q  <= 2'd0;
      first_q <= 8'd0;
      tag_q   <= 16'd0;
      vlen_q  <= 16'd0;
      left_q  <= 16'd0;
      start_q <= '0;
      pos_q   <= '0;
      cnt_q   <= 16'd0;
      err_q   <= ST_OK;
    end else begin
      in_v_q  <= in_valid_i;
      phase_q <= phase_d;
      hidx_q  <= hidx_d;
      first_q <= first_d;
      tag_q   <= tag_d;
      vlen_q  <= vlen_d;
      left_q  <= left_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      cnt_q   <= cnt_d;
      err_q   <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i) in_q <= in_item_i;
  end

endmodule

>>> sv/tlvd_out_fifo.sv
// Result queue: takes up to two items per cycle, pops one per ready cycle.
// Depends on tlvd_pkg.
module tlvd_out_fifo
  import tlvd_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  push_t     push_i,
  output logic      space_o,
  output logic      valid_o,
  input  logic      ready_i,
  output out_item_t item_o
);

  out_item_t            mem_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wptr_q, rptr_q;
  logic [FIFO_AW:0]     count_q;
  logic                 pop;

  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rptr_q];
  assign pop     = valid_o & ready_i;
  // room for the item in the input register plus one more
  assign space_o = count_q <= (FIFO_AW + 1)'(FIFO_DEPTH - 4);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= '0;
      rptr_q  <= '0;
      count_q <= '0;
    end else begin
      wptr_q  <= wptr_q + FIFO_AW'(push_i.num);
      rptr_q  <= rptr_q + FIFO_AW'(pop);
      count_q <= count_q + (FIFO_AW + 1)'(push_i.num) - (FIFO_AW + 1)'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.num != 2'd0) mem_q[wptr_q] <= push_i.first;
    if (push_i.num == 2'd2) mem_q[wptr_q + FIFO_AW'(1)] <= push_i.second;
  end

endmodule

>>> sv/tlvd_checker.sv
// Port-level checks on the deframer's result channel, bound to the top level.
// Depends on tlvd_pkg and tlv_header_deframer.
module tlvd_checker
  import tlvd_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_item
);

  property p_hold;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && !out_ready |=> out_valid && $stable(out_item);
  endproperty
  a_hold: assert property (p_hold) else $error("result changed while stalled");

  property p_last_is_summary;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && out_item.last |-> out_item.record_kind == KIND_SUMMARY &&
        out_item.header_length == 3'd0 && out_item.tag == 16'd0;
  endproperty
  a_last_is_summary: assert property (p_last_is_summary)
    else $error("last result is not a clean summary");

  property p_record_shape;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && out_item.record_kind == KIND_RECORD |->
        !out_item.last && out_item.status == ST_OK &&
        (out_item.header_length == 3'd2 || out_item.header_length == 3'd4) &&
        out_item.record_count != 16'd0;
  endproperty
  a_record_shape: assert property (p_record_shape)
    else $error("malformed TLV record");

  property p_summary_last;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid && out_item.record_kind == KIND_SUMMARY |->
        out_item.last && out_item.status != 2'd3;
  endproperty
  a_summary_last: assert property (p_summary_last)
    else $error("summary without last or bad status");

endmodule

bind tlv_header_deframer tlvd_checker u_chk (
  .clk_i     (clk_i),
  .rst_ni    (rst_ni),
  .out_valid (result_o.valid),
  .out_ready (result_o.ready),
  .out_item  (result_o.item)
);

>>> dv/tb_tlv_header_deframer.sv
`timescale 1ns / 1ps
// Self-checking testbench for tlv_header_deframer: streams byte buffers under several
// register settings, predicts every TLV record and summary, compares them as they leave.
// Depends on tlvd_pkg, tlvd_if and the deframer RTL.
module tb_tlv_header_deframer
  import tlvd_pkg::*;
();

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_VALUE,
    PH_STOPPED
  } parse_phase_e;

  localparam int unsigned DRAIN_CYCLES  = 8;
  localparam int unsigned SETTLE_LIMIT  = 2000;
  localparam int unsigned MAX_PRINTED   = 40;
  localparam int unsigned PHASE_ITEMS   = 100;
  localparam int unsigned RANDOM_PHASES = 8;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              in_valid  = 1'b0;
  in_item_t          in_item   = '0;
  logic              out_ready = 1'b0;
  logic              psel      = 1'b0;
  logic              penable   = 1'b0;
  logic              pwrite    = 1'b0;
  logic [PADDR_W-1:0] paddr    = '0;
  logic [31:0]       pwdata    = '0;
  logic [31:0]       prdata;
  logic              pready;

  tlvd_in_if  byte_if ();
  tlvd_out_if res_if ();

  assign byte_if.valid = in_valid;
  assign byte_if.item  = in_item;
  assign res_if.ready  = out_ready;

  tlv_header_deframer uut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_if),
    .result_o (res_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // register copy and parse state of the predictor
  cfg_t         cfg_mirror;
  parse_phase_e ph;
  logic [1:0]   hdr_idx;
  logic [7:0]   first_b;
  logic [15:0]  cur_tag;
  logic [15:0]  val_len;
  logic [15:0]  val_left;
  logic [15:0]  tlv_count;
  logic [23:0]  rec_start;
  logic [23:0]  pos;
  status_e      err;

  in_item_t  buffer_bytes_q[$];
  out_item_t parsed_results_q[$];

  int unsigned bytes_queued = 0;
  int unsigned bytes_taken  = 0;
  int unsigned n_records    = 0;
  int unsigned n_summaries  = 0;
  int unsigned n_buffers    = 0;
  int unsigned n_settings   = 0;
  int unsigned n_fail       = 0;
  logic        steady       = 1'b0;

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (n_fail < MAX_PRINTED)
      $display("%0t mismatch %s: got %0h, want %0h", $time, what, got, want);
    n_fail++;
  endtask

  task automatic clear_parse();
    ph        = PH_HEADER;
    hdr_idx   = 2'd0;
    first_b   = 8'h00;
    cur_tag   = 16'h0000;
    val_len   = 16'h0000;
    val_left  = 16'h0000;
    rec_start = 24'h000000;
    pos       = 24'h000000;
    tlv_count = 16'h0000;
    err       = ST_OK;
  endtask

  // masks are taken as they stand when the record leaves
  task automatic close_record();
    out_item_t r;
    r = '0;
    if (tlv_count != CNT_SAT) tlv_count++;
    r.record_kind   = KIND_RECORD;
    r.tag           = cur_tag;
    r.header_length = ((first_b & cfg_mirror.wide_header_mask) != 0) ? 3'd4 : 3'd2;
    r.data_length   = val_len;
    r.offset        = rec_start;
    r.non_critical  = (first_b & cfg_mirror.non_critical_mask) != 0;
    r.forward       = (first_b & cfg_mirror.forward_mask) != 0;
    r.record_count  = tlv_count;
    r.status        = ST_OK;
    r.last          = 1'b0;
    parsed_results_q.push_back(r);
    ph      = PH_HEADER;
    hdr_idx = 2'd0;
  endtask

  task automatic end_header(input logic lastb);
    hdr_idx = 2'd0;
    if (val_len == 16'd0) begin
      close_record();
    end else begin
      val_left = val_len;
      ph       = PH_VALUE;
      if (lastb) err = ST_INVALID_FORMAT;
    end
  endtask

  task automatic parse_byte(input in_item_t it);
    out_item_t  s;
    logic [7:0] b;
    logic       lastb;
    b     = it.byte_value;
    lastb = it.last_byte;
    case (ph)
      PH_VALUE: begin
        if (val_left != 16'd0) val_left--;
        if (val_left == 16'd0) close_record();
        else if (lastb) err = ST_INVALID_FORMAT;
      end
      PH_HEADER: begin
        case (hdr_idx)
          2'd0: begin
            if (cfg_mirror.max_records != 16'd0 && tlv_count >= cfg_mirror.max_records) begin
              ph = PH_STOPPED;
            end else begin
              first_b   = b;
              rec_start = pos;
              if (lastb) err = ST_INVALID_ARGUMENT;
              else hdr_idx = 2'd1;
            end
          end
          2'd1: begin
            if ((first_b & cfg_mirror.wide_header_mask) != 0) begin
              cur_tag = {first_b & cfg_mirror.type_mask, b};
              if (lastb) err = ST_INVALID_FORMAT;
              else hdr_idx = 2'd2;
            end else begin
              cur_tag = {8'h00, first_b & cfg_mirror.type_mask};
              val_len = {8'h00, b};
              end_header(lastb);
            end
          end
          2'd2: begin
            val_len = {b, 8'h00};
            if (lastb) err = ST_INVALID_FORMAT;
            else hdr_idx = 2'd3;
          end
          default: begin
            val_len = val_len | {8'h00, b};
            end_header(lastb);
          end
        endcase
      end
      default: ;
    endcase
    pos = pos + 24'd1;
    if (lastb) begin
      s              = '0;
      s.record_kind  = KIND_SUMMARY;
      s.record_count = tlv_count;
      s.status       = err;
      s.last         = 1'b1;
      parsed_results_q.push_back(s);
      clear_parse();
    end
  endtask

  task automatic check_result(input out_item_t got);
    out_item_t want;
    if (parsed_results_q.size() == 0) begin
      report_mismatch("result with nothing due, kind", 32'(got.record_kind), 32'd0);
    end else begin
      want = parsed_results_q.pop_front();
      if (want.record_kind == KIND_SUMMARY) n_summaries++;
      else n_records++;
      if (got.record_kind !== want.record_kind)
        report_mismatch("record_kind", 32'(got.record_kind), 32'(want.record_kind));
      if (got.tag !== want.tag) report_mismatch("tag", 32'(got.tag), 32'(want.tag));
      if (got.header_length !== want.header_length)
        report_mismatch("header_length", 32'(got.header_length),
                        32'(want.header_length));
      if (got.data_length !== want.data_length)
        report_mismatch("data_length", 32'(got.data_length), 32'(want.data_length));
      if (got.offset !== want.offset)
        report_mismatch("offset", 32'(got.offset), 32'(want.offset));
      if (got.non_critical !== want.non_critical)
        report_mismatch("non_critical", 32'(got.non_critical), 32'(want.non_critical));
      if (got.forward !== want.forward)
        report_mismatch("forward", 32'(got.forward), 32'(want.forward));
      if (got.record_count !== want.record_count)
        report_mismatch("record_count", 32'(got.record_count), 32'(want.record_count));
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.last !== want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
    end
  endtask

  // byte driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && byte_if.ready) begin
        parse_byte(in_item);
        bytes_taken++;
      end
      if (!in_valid || byte_if.ready) begin
        if (buffer_bytes_q.size() != 0 && (steady || $urandom_range(99) >= 33)) begin
          in_valid <= 1'b1;
          in_item  <= buffer_bytes_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
    end else begin
      if (res_if.valid && out_ready) check_result(res_if.item);
      out_ready <= steady || ($urandom_range(99) >= 33);
    end
  end

  task automatic write_reg(input reg_idx_e idx, input logic [31:0] val);
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({idx, 2'b00});
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MAX_RECORDS:  cfg_mirror.max_records       = val[15:0];
      REG_WIDE_MASK:    cfg_mirror.wide_header_mask  = val[7:0];
      REG_NONCRIT_MASK: cfg_mirror.non_critical_mask = val[7:0];
      REG_FWD_MASK:     cfg_mirror.forward_mask      = val[7:0];
      REG_TYPE_MASK:    cfg_mirror.type_mask         = val[7:0];
      default: ;
    endcase
  endtask

  task automatic write_config(input cfg_t c);
    write_reg(REG_MAX_RECORDS, {16'h0000, c.max_records});
    write_reg(REG_WIDE_MASK, {24'h000000, c.wide_header_mask});
    write_reg(REG_NONCRIT_MASK, {24'h000000, c.non_critical_mask});
    write_reg(REG_FWD_MASK, {24'h000000, c.forward_mask});
    write_reg(REG_TYPE_MASK, {24'h000000, c.type_mask});
    n_settings++;
  endtask

  task automatic put_byte(input logic [7:0] b, input logic lastb);
    in_item_t it;
    it.byte_value = b;
    it.last_byte  = lastb;
    buffer_bytes_q.push_back(it);
    bytes_queued++;
  endtask

  function automatic logic [7:0] make_first(input logic want_wide);
    logic [7:0] b;
    b = 8'($urandom);
    if (want_wide) b = b | cfg_mirror.wide_header_mask;
    else b = b & ~cfg_mirror.wide_header_mask;
    return b;
  endfunction

  function automatic int unsigned random_len();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 75) return $urandom_range(0, 6);
    if (r < 95) return $urandom_range(7, 40);
    return $urandom_range(41, 300);
  endfunction

  // one TLV; a truncated one stops short of its declared length
  task automatic put_tlv(input logic want_wide, input int unsigned dlen,
                         input logic truncate, input logic close);
    logic [7:0]  fb;
    logic        wide;
    logic [15:0] len;
    int unsigned sent;
    int unsigned i;
    fb   = make_first(want_wide);
    wide = (fb & cfg_mirror.wide_header_mask) != 0;
    if (!wide && dlen > 255) dlen = 255;
    if (truncate && dlen == 0) dlen = 1;
    len  = 16'(dlen);
    sent = truncate ? $urandom_range(0, dlen - 1) : dlen;
    put_byte(fb, 1'b0);
    if (wide) begin
      put_byte(8'($urandom), 1'b0);
      put_byte(len[15:8], 1'b0);
    end
    put_byte(len[7:0], close && sent == 0);
    for (i = 1; i <= sent; i++) put_byte(8'($urandom), close && i == sent);
  endtask

  task automatic put_buffer();
    int unsigned n;
    int unsigned i;
    int unsigned k;
    int unsigned pick;
    n    = $urandom_range(0, 4);
    pick = $urandom_range(99);
    for (i = 0; i < n; i++) put_tlv(1'($urandom_range(1)), random_len(), 1'b0, 1'b0);
    if (pick < 60) begin
      put_tlv(1'($urandom_range(1)), random_len(), 1'b0, 1'b1);
    end else if (pick < 70) begin
      put_byte(8'($urandom), 1'b1);
    end else if (pick < 80) begin
      put_byte(make_first(1'b1), 1'b0);
      k = $urandom_range(1, 2);
      for (i = 1; i <= k; i++) put_byte(8'($urandom), i == k);
    end else if (pick < 92) begin
      put_tlv(1'($urandom_range(1)), random_len(), 1'b1, 1'b1);
    end else begin
      k = $urandom_range(1, 10);
      for (i = 1; i <= k; i++) put_byte(8'($urandom), i == k);
    end
    n_buffers++;
  endtask

  task automatic wait_settled();
    int unsigned waited;
    while (bytes_taken != bytes_queued) @(posedge clk_i);
    waited = 0;
    while (parsed_results_q.size() != 0 && waited < SETTLE_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (parsed_results_q.size() != 0) begin
      report_mismatch("results never delivered", 32'(parsed_results_q.size()), 32'd0);
      parsed_results_q.delete();
    end
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  initial begin
    cfg_t        c;
    cfg_t        rst_cfg;
    int unsigned p;
    int unsigned start;
    rst_cfg    = '{RST_MAX_RECORDS, RST_WIDE_MASK, RST_NONCRIT_MASK, RST_FWD_MASK,
                   RST_TYPE_MASK};
    cfg_mirror = rst_cfg;
    clear_parse();
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // narrow empty TLV, then wide TLV closing on the final byte
    put_byte(8'h7f, 1'b0); put_byte(8'h00, 1'b0);
    put_byte(8'hff, 1'b0); put_byte(8'hff, 1'b0); put_byte(8'h00, 1'b0);
    put_byte(8'h02, 1'b0); put_byte(8'hff, 1'b0); put_byte(8'h00, 1'b1);
    put_byte(8'h00, 1'b1);                                           // lone header byte
    put_byte(8'h80, 1'b0); put_byte(8'h12, 1'b1);                    // short wide header
    put_byte(8'h01, 1'b0); put_byte(8'h03, 1'b0); put_byte(8'haa, 1'b1); // cut value
    put_byte(8'h1f, 1'b0); put_byte(8'h00, 1'b1);                    // empty TLV at end
    // wide header left half done across a mask change
    put_byte(8'h81, 1'b0); put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);
    n_buffers += 5;
    wait_settled();
    write_reg(REG_WIDE_MASK, 32'h0);
    put_byte(8'h01, 1'b0); put_byte(8'hee, 1'b1);
    wait_settled();
    write_reg(REG_WIDE_MASK, {24'h000000, RST_WIDE_MASK});
    write_reg(REG_MAX_RECORDS, 32'd1);
    put_byte(8'h00, 1'b0); put_byte(8'h00, 1'b0);                    // limit then ignored
    put_byte(8'h05, 1'b0); put_byte(8'h00, 1'b1);
    n_buffers += 2;
    wait_settled();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        0: c = rst_cfg;
        1: c = '{16'hffff, 8'hff, 8'hff, 8'hff, 8'hff};
        2: c = '{16'd1, 8'h00, 8'h00, 8'h00, 8'h00};
        default: begin
          c.max_records       = ($urandom_range(1) == 0) ? 16'd0 : 16'($urandom_range(1, 4));
          c.wide_header_mask  = ($urandom_range(3) == 0) ? 8'($urandom)
                                                         : 8'h01 << $urandom_range(7);
          c.non_critical_mask = 8'($urandom);
          c.forward_mask      = 8'($urandom);
          c.type_mask         = 8'($urandom);
        end
      endcase
      write_config(c);
      steady = (p == 3);
      start  = bytes_queued;
      while (bytes_queued - start < (steady ? 2 * PHASE_ITEMS : PHASE_ITEMS)) put_buffer();
      wait_settled();
    end
    steady = 1'b0;

    $display("Streamed %0d buffers (%0d bytes) under %0d register settings.",
             n_buffers, bytes_taken, n_settings);
    $display("Compared %0d TLV records and %0d buffer summaries.", n_records, n_summaries);
    if (n_fail == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
